[hdl/assert_macros.svh]
// assertion macros used by the smoother rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/cps_pkg.sv]
// types, constants and the corner cut function of the polyline smoother
`default_nettype none

package cps_pkg;

    // coordinate format: signed fixed point with 8 fraction bits
    localparam int COORD_WIDTH = 24;
    // result list: one head point, five cut pairs, one tail point
    localparam int LIST_DEPTH  = 12;
    localparam int IDX_W       = $clog2(LIST_DEPTH + 1);
    // round one points seen by round two for one input word
    localparam int CHAIN_DEPTH = 6;
    localparam int CHAIN_W     = $clog2(CHAIN_DEPTH);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   last_point;
    } t_in_word;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        logic   out_last;
    } t_out_word;

    // how far into the current polyline we are
    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_ONE,
        PH_TWO,
        PH_STREAM
    } t_phase;

    // floor((3a + b) / 4), result always lies between a and b
    function automatic t_coord cut(t_coord a, t_coord b);
        logic [COORD_WIDTH+1:0] ea;
        logic [COORD_WIDTH+1:0] eb;
        logic [COORD_WIDTH+1:0] s;
        ea = {{2{a[COORD_WIDTH-1]}}, a};
        eb = {{2{b[COORD_WIDTH-1]}}, b};
        s  = ea + ea + ea + eb;
        return t_coord'(s[COORD_WIDTH+1:2]);
    endfunction

    function automatic t_point cut_pt(t_point a, t_point b);
        t_point r;
        r.x = cut(a.x, b.x);
        r.y = cut(a.y, b.y);
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/chaikin_polyline_smoother.sv]
// flow: a word reaches the input register, its results are computed in one pass into
// the result list, and the registered list feeds the output words
// drain: the result list drains one word per cycle while the output is not stalled; a
// middle point gives 4 results, a last point 7, the third point 9 or 12, a point that
// is only held gives none; the next word is taken as the last result goes out
// reset: synchronous active low, clears the handshake state and starts a new polyline
`default_nettype none

module chaikin_polyline_smoother (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire cps_pkg::t_in_word   i_in_word,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output cps_pkg::t_out_word       o_out_word
);
    import cps_pkg::*;

`include "assert_macros.svh"

    // input register
    logic     r_in_valid;
    t_in_word r_in;

    // polyline state
    t_phase   r_phase;
    t_phase   n_phase;
    t_point   r_held [2];
    t_point   r_r1_prev;
    t_point   r_r2_prev;

    // result list
    t_point           r_list [LIST_DEPTH];
    t_point           n_list [LIST_DEPTH];
    logic             r_busy;
    logic [IDX_W-1:0] r_rd;
    logic [IDX_W-1:0] r_end;
    logic             r_tail;

    // one pass signals
    t_point           w_p;
    t_point           w_q [CHAIN_DEPTH];
    t_point           w_a;
    t_point           w_b;
    t_point           w_c;
    t_point           w_d;
    logic             w_head;
    logic [CHAIN_W-1:0] w_np;
    logic             w_tail;
    logic [IDX_W-1:0] w_start;
    logic [IDX_W-1:0] w_end;
    logic [IDX_W-1:0] w_tail_idx;
    logic             w_final_rd;
    logic             w_list_free;
    logic             w_load;

    // handshake
    assign w_final_rd  = (r_rd == r_end - IDX_W'(1));
    assign w_list_free = !r_busy || (!i_out_stall && w_final_rd);
    assign w_load      = r_in_valid && w_list_free;
    assign o_in_stall  = r_in_valid && !w_list_free;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall) begin
            r_in <= i_in_word;
        end
    end

    // round one points for this word and the shape of the result list
    always_comb begin
        w_p = '{x: r_in.point_x, y: r_in.point_y};
        w_a = cut_pt(r_held[0], r_held[1]);
        w_b = cut_pt(r_held[1], r_held[0]);
        w_c = '0;
        w_d = '0;
        for (int k = 0; k < CHAIN_DEPTH; k++) begin
            w_q[k] = w_p;
        end
        w_head = 1'b0;
        w_np   = '0;
        w_tail = r_in.last_point;
        case (r_phase)
            PH_TWO: begin
                w_c    = cut_pt(r_held[1], w_p);
                w_d    = cut_pt(w_p, r_held[1]);
                w_q[0] = r_held[0];
                w_q[1] = w_a;
                w_q[2] = w_b;
                w_q[3] = w_c;
                w_q[4] = w_d;
                w_head = 1'b1;
                w_np   = r_in.last_point ? CHAIN_W'(5) : CHAIN_W'(4);
            end
            PH_STREAM: begin
                w_c    = cut_pt(r_r1_prev, w_p);
                w_d    = cut_pt(w_p, r_r1_prev);
                w_q[0] = r_r2_prev;
                w_q[1] = w_c;
                w_q[2] = w_d;
                w_np   = r_in.last_point ? CHAIN_W'(3) : CHAIN_W'(2);
            end
            PH_ONE: begin
                // short polyline: held point passes through on the last word
                w_q[0] = r_held[0];
                w_head = r_in.last_point;
            end
            default: begin
                w_q[0] = r_held[0];
            end
        endcase
        w_start    = w_head ? IDX_W'(0) : IDX_W'(1);
        w_tail_idx = IDX_W'(1) + IDX_W'({w_np, 1'b0});
        w_end      = w_tail_idx + IDX_W'(w_tail);
    end

    // round two: head point, cut pairs, tail point
    always_comb begin
        n_list[0] = w_q[0];
        for (int k = 0; k < CHAIN_DEPTH - 1; k++) begin
            n_list[1 + 2 * k] = cut_pt(w_q[k], w_q[k + 1]);
            n_list[2 + 2 * k] = cut_pt(w_q[k + 1], w_q[k]);
        end
        n_list[LIST_DEPTH - 1] = w_p;
        for (int s = 1; s < LIST_DEPTH; s++) begin
            if (w_tail && (IDX_W'(s) == w_tail_idx)) begin
                n_list[s] = w_p;
            end
        end
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_load) begin
            case (r_phase)
                PH_EMPTY:  n_phase = r_in.last_point ? PH_EMPTY : PH_ONE;
                PH_ONE:    n_phase = r_in.last_point ? PH_EMPTY : PH_TWO;
                PH_TWO:    n_phase = r_in.last_point ? PH_EMPTY : PH_STREAM;
                PH_STREAM: n_phase = r_in.last_point ? PH_EMPTY : PH_STREAM;
                default:   n_phase = PH_EMPTY;
            endcase
        end
    end

    // polyline state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EMPTY;
        end else begin
            r_phase <= n_phase;
        end
        if (w_load && !r_in.last_point && (r_phase == PH_EMPTY)) begin
            r_held[0] <= w_p;
        end
        if (w_load && !r_in.last_point && (r_phase == PH_ONE)) begin
            r_held[1] <= w_p;
        end
        if (w_load && ((r_phase == PH_TWO) || (r_phase == PH_STREAM))) begin
            r_r1_prev <= w_p;
            r_r2_prev <= w_q[w_np];
        end
    end

    // result list load and drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rd   <= '0;
            r_end  <= '0;
            r_tail <= 1'b0;
        end else if (w_load) begin
            r_busy <= (w_end != w_start);
            r_rd   <= w_start;
            r_end  <= w_end;
            r_tail <= w_tail;
        end else if (r_busy && !i_out_stall) begin
            if (w_final_rd) begin
                r_busy <= 1'b0;
            end else begin
                r_rd <= r_rd + IDX_W'(1);
            end
        end
        if (w_load) begin
            r_list <= n_list;
        end
    end

    // output word
    assign o_out_valid = r_busy;
    assign o_out_word  = '{out_x:    r_list[r_rd].x,
                           out_y:    r_list[r_rd].y,
                           out_last: r_tail && w_final_rd};

    // checks
    `ASSERT_IMP(a_rd_in_range, i_clk, i_rst_n, r_busy,
        (r_rd < r_end) && (r_end <= IDX_W'(LIST_DEPTH)), "read index outside result list")
    `ASSERT_IMP(a_stall_needs_full, i_clk, i_rst_n, o_in_stall,
        r_in_valid && r_busy, "input stalled while result list can take a word")
    `ASSERT_NXT(a_last_restarts, i_clk, i_rst_n, w_load && r_in.last_point,
        r_phase == PH_EMPTY, "last point did not restart the polyline")
    `ASSERT_NXT(a_idle_after_last, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && o_out_word.out_last && !w_load,
        !o_out_valid, "output still valid after final word of polyline")

endmodule

`default_nettype wire
